// ----- design/ifrr_pkg.sv -----
// ----------------------------------------------------------------------------
// ifrr_pkg
// Shared types and constants of the isolated flag run remover.
// ----------------------------------------------------------------------------
package ifrr_pkg;

  localparam int MAX_N_DEF        = 16;
  localparam int MAX_CHANNELS_DEF = 4096;
  localparam int WINDOW_W         = 5;
  localparam int CHAN_IDX_W       = 12;
  localparam int RUN_W            = 2;

  localparam logic [WINDOW_W-1:0] WINDOW_RST = 5'd1;

  localparam logic [RUN_W-1:0] RUN_NONE   = 2'd0;
  localparam logic [RUN_W-1:0] RUN_FIRST  = 2'd1;
  localparam logic [RUN_W-1:0] RUN_SECOND = 2'd2;
  localparam logic [RUN_W-1:0] RUN_SAT    = 2'd3;

  typedef struct packed {
    logic flag_in;
    logic last_in;
  } ifrr_in_t;

  typedef struct packed {
    logic                  flag_out;
    logic [CHAN_IDX_W-1:0] channel_index;
    logic                  last_out;
  } ifrr_out_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic flag;
  } ifrr_cell_ctrl_t;

  typedef struct packed {
    logic emit;
    logic restart;
  } ifrr_head_ctrl_t;

endpackage

// ----- design/isolated_flag_run_remover_core.sv -----
// ----------------------------------------------------------------------------
// isolated_flag_run_remover_core
// Clears short flagged runs of one or two channels that have no flagged
// neighbor within window_n channels on either side.
//
//   channel  direction  word        handshake
//   in_      input      ifrr_in_t   in_valid / in_stall
//   out_     output     ifrr_out_t  out_valid / out_stall
//   cfg_     input      window_n    cfg_we, no wait
//
// In steady state with out_stall low, one word is taken and one result given
// every cycle; a channel's result leaves window_n+1 words after it entered.
// A last word causes a flush of up to MAX_N+2 results, one per cycle while
// out_stall is low, through the head of the cell chain, during which input
// is stalled. Lowering the window mid-spectrum drains the surplus the same
// way. Reset is synchronous and needs no clearing pass; out_stall only holds
// input when the next accepted word would need the output register.
// ----------------------------------------------------------------------------
module isolated_flag_run_remover_core #(
  parameter int MAX_N        = ifrr_pkg::MAX_N_DEF,
  parameter int MAX_CHANNELS = ifrr_pkg::MAX_CHANNELS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  ifrr_pkg::ifrr_in_t              in_word,
  output logic                            out_valid,
  input  logic                            out_stall,
  output ifrr_pkg::ifrr_out_t             out_word,
  input  logic                            cfg_we,
  input  logic [ifrr_pkg::WINDOW_W-1:0]   cfg_wdata
);

  localparam int D   = MAX_N + 2;
  localparam int GW  = $clog2(MAX_N + 1);
  localparam int CW  = $clog2(MAX_N + 3);
  localparam int IW  = $clog2(MAX_CHANNELS);
  localparam int IXW = (IW > ifrr_pkg::CHAN_IDX_W) ? IW : ifrr_pkg::CHAN_IDX_W;

  logic [ifrr_pkg::WINDOW_W-1:0] window_r;
  logic [CW-1:0]                 cnt_r;
  logic [CW-1:0]                 cnt_nxt;
  logic                          flush_r;
  logic                          flush_nxt;
  logic [IXW-1:0]                idx_r;
  logic [IXW-1:0]                idx_nxt;
  logic                          out_valid_r;
  ifrr_pkg::ifrr_out_t           out_word_r;

  logic [GW-1:0]                 n_eff;
  logic [CW-1:0]                 n_plus1;
  logic                          out_free;
  logic                          acc;
  logic [CW-1:0]                 cnt_v;
  logic                          flush_v;
  logic                          pending;
  logic                          emit;
  logic                          out_last;
  logic                          result;
  logic [D-1:0]                  view;
  logic [D-1:0]                  view_next;
  ifrr_pkg::ifrr_cell_ctrl_t     cell_ctrl [D];
  ifrr_pkg::ifrr_head_ctrl_t     head_ctrl;

  always_comb begin
    if (window_r == '0) begin
      n_eff = GW'(1);
    end else if (32'(window_r) > 32'(MAX_N)) begin
      n_eff = GW'(MAX_N);
    end else begin
      n_eff = GW'(window_r);
    end
  end

  assign n_plus1  = CW'(n_eff) + CW'(1);
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = flush_r || (cnt_r > n_plus1) ||
                    (!out_free && (in_word.last_in || cnt_r == n_plus1));
  assign acc      = in_valid && !in_stall;
  assign cnt_v    = cnt_r + CW'(acc);
  assign flush_v  = flush_r || (acc && in_word.last_in);
  assign pending  = flush_v ? (cnt_v != '0) : (cnt_v > n_plus1);
  assign emit     = pending && out_free;
  assign out_last = flush_v && (cnt_v == CW'(1));

  assign head_ctrl = '{emit: emit, restart: out_last};
  assign view_next = {1'b0, view[D-1:1]};

  for (genvar k = 0; k < D; k++) begin : g_cell
    assign cell_ctrl[k] = '{push: acc && (cnt_r == CW'(k)), pop: emit,
                            flag: in_word.flag_in};
    ifrr_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (cell_ctrl[k]),
      .next_view (view_next[k]),
      .view      (view[k])
    );
  end

  ifrr_head #(
    .MAX_N (MAX_N)
  ) u_head (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (head_ctrl),
    .view   (view),
    .n_eff  (n_eff),
    .result (result)
  );

  always_comb begin
    cnt_nxt   = cnt_v - CW'(emit);
    flush_nxt = flush_v && !(emit && out_last);
    idx_nxt   = idx_r;
    if (emit) begin
      if (out_last) begin
        idx_nxt = '0;
      end else if (idx_r < IXW'(MAX_CHANNELS - 1)) begin
        idx_nxt = idx_r + IXW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r    <= ifrr_pkg::WINDOW_RST;
      cnt_r       <= '0;
      flush_r     <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        window_r <= cfg_wdata;
      end
      cnt_r   <= cnt_nxt;
      flush_r <= flush_nxt;
      idx_r   <= idx_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_word_r <= '{flag_out: result,
                      channel_index: idx_r[ifrr_pkg::CHAN_IDX_W-1:0],
                      last_out: out_last};
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  a_accept_fits : assert property (@(posedge clk) disable iff (!rst_n)
    acc && pending |-> out_free)
    else $error("Accepted word needs a result slot that is not free.");

  a_window_tail_clear : assert property (@(posedge clk) disable iff (!rst_n)
    (view >> cnt_v) == '0)
    else $error("Cell beyond the fill level holds a flag.");

  a_flush_nonempty : assert property (@(posedge clk) disable iff (!rst_n)
    flush_r |-> cnt_r != '0)
    else $error("Flush pending with an empty window.");

  a_restart : assert property (@(posedge clk) disable iff (!rst_n)
    emit && out_last |=> cnt_r == '0 && idx_r == '0 && !flush_r)
    else $error("Stream state not restored after the last word.");

endmodule

// ----- design/ifrr_cell.sv -----
// ----------------------------------------------------------------------------
// ifrr_cell
// One place of the flag window. It loads a new flag when selected and hands
// its flag to the neighbor below when the head pops.
// ----------------------------------------------------------------------------
module ifrr_cell (
  input  logic                     clk,
  input  logic                     rst_n,
  input  ifrr_pkg::ifrr_cell_ctrl_t ctrl,
  input  logic                     next_view,
  output logic                     view
);

  logic hold_r;
  logic hold_nxt;

  assign view = ctrl.push ? ctrl.flag : hold_r;

  always_comb begin
    hold_nxt = ctrl.pop ? next_view : view;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= 1'b0;
    end else begin
      hold_r <= hold_nxt;
    end
  end

endmodule

// ----- design/ifrr_head.sv -----
// ----------------------------------------------------------------------------
// ifrr_head
// Decides the smoothed flag of the oldest channel in the window and tracks
// the gap before the current run and the position within the run.
// ----------------------------------------------------------------------------
module ifrr_head #(
  parameter int MAX_N = ifrr_pkg::MAX_N_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  ifrr_pkg::ifrr_head_ctrl_t             ctrl,
  input  logic [MAX_N+1:0]                      view,
  input  logic [$clog2(MAX_N+1)-1:0]            n_eff,
  output logic                                  result
);

  localparam int D  = MAX_N + 2;
  localparam int GW = $clog2(MAX_N + 1);
  localparam int CW = $clog2(MAX_N + 3);

  logic [GW-1:0]                gap_r;
  logic [GW-1:0]                gap_nxt;
  logic [ifrr_pkg::RUN_W-1:0]   run_r;
  logic [ifrr_pkg::RUN_W-1:0]   run_nxt;
  logic [ifrr_pkg::RUN_W-1:0]   run_inc;
  logic [D-1:0]                 mask0;
  logic [D-1:0]                 mask1;
  logic [D-1:0]                 mask;
  logic [CW-1:0]                n_w;
  logic                         short0;
  logic                         short1;
  logic                         clear;

  assign n_w = CW'(n_eff);

  always_comb begin
    mask0 = '0;
    mask1 = '0;
    for (int k = 1; k < D; k++) begin
      mask0[k] = (CW'(k) <= n_w);
      mask1[k] = (k >= 2) && (CW'(k) <= n_w + CW'(1));
    end
  end

  always_comb begin
    run_inc = (run_r == ifrr_pkg::RUN_SAT) ? ifrr_pkg::RUN_SAT : run_r + ifrr_pkg::RUN_FIRST;
    short0  = !view[1] && (run_inc == ifrr_pkg::RUN_FIRST || run_inc == ifrr_pkg::RUN_SECOND);
    short1  = (run_inc == ifrr_pkg::RUN_FIRST) && view[1] && !view[2];
    mask    = short0 ? mask0 : mask1;
    clear   = view[0] && (short0 || short1) && (gap_r >= n_eff) && ((view & mask) == '0);
    result  = view[0] && !clear;
  end

  always_comb begin
    gap_nxt = gap_r;
    run_nxt = run_r;
    if (ctrl.emit) begin
      if (ctrl.restart) begin
        gap_nxt = GW'(MAX_N);
        run_nxt = ifrr_pkg::RUN_NONE;
      end else if (view[0]) begin
        run_nxt = run_inc;
      end else begin
        run_nxt = ifrr_pkg::RUN_NONE;
        if (run_r != ifrr_pkg::RUN_NONE) begin
          gap_nxt = GW'(1);
        end else if (gap_r < GW'(MAX_N)) begin
          gap_nxt = gap_r + GW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r <= GW'(MAX_N);
      run_r <= ifrr_pkg::RUN_NONE;
    end else begin
      gap_r <= gap_nxt;
      run_r <= run_nxt;
    end
  end

endmodule
